### design/zc_pkg.sv
// ----------------------------------------------------------------------------
// zc_pkg: shared constants for the Zadoff-Chu sample generator
// Sizes of the fixed-width fields and registers, the CORDIC angle table
// and the register index codes.
// ----------------------------------------------------------------------------
package zc_pkg;

  localparam int IDX_W  = 12;
  localparam int ROOT_W = 12;
  localparam int LEN_W  = 13;
  localparam int CFG_W  = 13;

  localparam logic CFG_ROOT = 1'b0;
  localparam logic CFG_LEN  = 1'b1;

  localparam int CORDIC_STEPS = 30;
  localparam int WORK_FRAC    = 30;
  localparam int ACC_W        = 34;
  localparam logic signed [ACC_W-1:0] CORDIC_X0 = 34'sd652032874;

  function automatic logic signed [ACC_W-1:0] turn_atan(input int k);
    logic signed [ACC_W-1:0] r;
    case (k)
      0: r = 34'sd536870912;  1: r = 34'sd316933406;  2: r = 34'sd167458907;
      3: r = 34'sd85004756;   4: r = 34'sd42667331;   5: r = 34'sd21354465;
      6: r = 34'sd10679838;   7: r = 34'sd5340245;    8: r = 34'sd2670163;
      9: r = 34'sd1335087;   10: r = 34'sd667544;    11: r = 34'sd333772;
      12: r = 34'sd166886;   13: r = 34'sd83443;     14: r = 34'sd41722;
      15: r = 34'sd20861;    16: r = 34'sd10430;     17: r = 34'sd5215;
      18: r = 34'sd2608;     19: r = 34'sd1304;      20: r = 34'sd652;
      21: r = 34'sd326;      22: r = 34'sd163;       23: r = 34'sd81;
      24: r = 34'sd41;       25: r = 34'sd20;        26: r = 34'sd10;
      27: r = 34'sd5;        28: r = 34'sd3;         29: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### design/zadoff_chu_sample_generator.sv
// ----------------------------------------------------------------------------
// zadoff_chu_sample_generator: one complex Zadoff-Chu sample per index
// Modular phase, reciprocal-based quantization and a pipelined CORDIC.
// ----------------------------------------------------------------------------
// One index is accepted every cycle while in_stall is low; each transfer returns the sample
// exp(-j*pi*m/N) in Q1.15 (OUT_BITS wide), or zero with bad_request set
// when the index, root or length is out of range. An item passes 40
// register stages: eight phase stages (u*i product, quotient estimate,
// mod 2N fix, a*b product, quotient estimate, mod 2N fix, quantization
// quotient estimate, quantization fix and negation), the CORDIC preload,
// the 30-step CORDIC pipeline with one step per stage, and the output
// register. The whole pipeline advances together and freezes when the
// output register is held by out_stall, so nothing is lost or repeated.
// root/seq_length must be written while idle.
// Modular reduction uses a Barrett style quotient estimate computed from
// the length; the reciprocal is recomputed by a short divide after reset
// and after each length write, and in_stall stays high while it runs.
module zadoff_chu_sample_generator #(
  parameter int MAX_LEN    = 4096,
  parameter int PHASE_BITS = 16,
  parameter int OUT_BITS   = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [zc_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [zc_pkg::IDX_W-1:0]   in_sample_index,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [OUT_BITS-1:0] out_sample_re,
  output logic signed [OUT_BITS-1:0] out_sample_im,
  output logic                       out_bad_request
);
  import zc_pkg::*;

  // widths: values mod 2N stay below 2^14; products below 2^28
  localparam int MW  = LEN_W + 1;          // mod 2N values
  localparam int PW  = 2 * MW;             // products
  localparam int RW  = PW + 2;             // reciprocal bits: floor(2^RW / 2N)
  localparam int QW  = PHASE_BITS + MW;    // quantization numerator
  localparam int RQ  = QW + 1;             // reciprocal bits for quantization
  localparam int DW  = (RW > RQ) ? RW : RQ; // divider numerator exponent
  localparam int ST  = CORDIC_STEPS;
  localparam int SH  = WORK_FRAC - (OUT_BITS - 1);

  // ---------------- configuration and reciprocal ----------------
  logic [ROOT_W-1:0] root_r;
  logic [LEN_W-1:0]  len_r;
  logic [MW-1:0]     two_n;
  logic [RW:0]       recip_r, recip_nxt;    // floor(2^RW / 2N)
  logic [RQ:0]       qrec_r, qrec_nxt;      // floor(2^RQ / 2N)
  // restoring divider for 2^DW / 2N, one quotient bit a cycle
  logic [7:0]        dcnt_r, dcnt_nxt;
  logic [MW:0]       drem_r, drem_nxt;
  logic [DW:0]       dquo_r, dquo_nxt;
  logic [MW+1:0]     dtrial;
  logic              div_busy;

  assign two_n    = {len_r, 1'b0};
  assign div_busy = (dcnt_r != '0);

  always_comb begin
    dcnt_nxt  = dcnt_r;
    drem_nxt  = drem_r;
    dquo_nxt  = dquo_r;
    recip_nxt = recip_r;
    qrec_nxt  = qrec_r;
    dtrial    = '0;
    if (dcnt_r != '0) begin
      // numerator bit is 1 only for the leading position
      dtrial = {drem_r, (dcnt_r == 8'(DW + 1))};
      if (dtrial >= {2'b0, two_n}) begin
        drem_nxt = (MW+1)'(dtrial - {2'b0, two_n});
        dquo_nxt = {dquo_r[DW-1:0], 1'b1};
      end else begin
        drem_nxt = dtrial[MW:0];
        dquo_nxt = {dquo_r[DW-1:0], 1'b0};
      end
      dcnt_nxt = dcnt_r - 8'd1;
      if (dcnt_r == 8'd1) begin
        // floor(2^k/2N) for k <= DW follows exactly by a right shift
        recip_nxt = (RW+1)'(dquo_nxt >> (DW - RW));
        qrec_nxt  = (RQ+1)'(dquo_nxt >> (DW - RQ));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= ROOT_W'(1);
      len_r  <= LEN_W'(63);
      dcnt_r <= 8'(DW + 1);
      drem_r <= '0;
      dquo_r <= '0;
    end else begin
      dcnt_r <= dcnt_nxt;
      drem_r <= drem_nxt;
      dquo_r <= dquo_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ROOT: root_r <= cfg_wdata[ROOT_W-1:0];
          CFG_LEN: begin
            len_r  <= cfg_wdata[LEN_W-1:0];
            dcnt_r <= 8'(DW + 1);
            drem_r <= '0;
            dquo_r <= '0;
          end
          default: ;
        endcase
      end
    end
    recip_r <= recip_nxt;
    qrec_r  <= qrec_nxt;
  end

  // quotient estimate floor(v * rc / 2^RW), at most two below v / 2N
  function automatic logic [PW-1:0] quot_est(input logic [PW-1:0] v,
                                             input logic [RW:0] rc);
    logic [PW+RW:0] prod;
    prod = {{(RW+1){1'b0}}, v} * {{PW{1'b0}}, rc};
    return PW'(prod >> RW);
  endfunction

  // remainder from the estimate, with two corrections
  function automatic logic [MW-1:0] mod_fix(input logic [PW-1:0] v,
                                            input logic [PW-1:0] q,
                                            input logic [MW-1:0] d);
    logic [PW+1:0] r;
    r = (PW+2)'({2'b0, v} - (PW+2)'(q * {{(PW-MW){1'b0}}, d}));
    if (r >= (PW+2)'(d)) r = r - (PW+2)'(d);
    if (r >= (PW+2)'(d)) r = r - (PW+2)'(d);
    return r[MW-1:0];
  endfunction

  // ---------------- pipeline control ----------------
  localparam int NS = 10 + ST; // stages incl. output
  logic adv;
  logic [NS-1:0] v_r;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv || div_busy;
  assign out_valid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[NS-2:0], in_valid && !div_busy};
  end

  // ---------------- stage 1: range check, u*i, i or i+1 ----------------
  logic [PW-1:0]  p1_r;
  logic [MW-1:0]  b1_r;
  logic           bad1_r;
  logic [IDX_W:0] ip1;
  assign ip1 = {1'b0, in_sample_index} + (IDX_W+1)'(len_r[0]);
  always_ff @(posedge clk) begin
    if (adv) begin
      bad1_r <= (len_r < LEN_W'(2)) || (32'(len_r) > MAX_LEN) || (root_r == '0)
                || ({1'b0, root_r} >= len_r) || ({1'b0, in_sample_index} >= len_r);
      p1_r   <= PW'(root_r) * PW'(in_sample_index);
      b1_r   <= MW'(ip1);
    end
  end

  // ---------------- stages 2-3: a = u*i mod 2N ----------------
  logic [PW-1:0] v2_r, q2_r;
  logic [MW-1:0] b2_r;
  logic          bad2_r;
  logic [MW-1:0] a3_r, b3_r;
  logic          bad3_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      v2_r   <= p1_r;
      q2_r   <= quot_est(p1_r, recip_r);
      b2_r   <= b1_r;
      bad2_r <= bad1_r;
      a3_r   <= mod_fix(v2_r, q2_r, two_n);
      b3_r   <= b2_r;
      bad3_r <= bad2_r;
    end
  end

  // ---------------- stages 4-6: m = a*b mod 2N ----------------
  logic [PW-1:0] p4_r;
  logic          bad4_r;
  logic [PW-1:0] v5_r, q5_r;
  logic          bad5_r;
  logic [MW-1:0] m6_r;
  logic          bad6_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      p4_r   <= PW'(a3_r) * PW'(b3_r);
      bad4_r <= bad3_r;
      v5_r   <= p4_r;
      q5_r   <= quot_est(p4_r, recip_r);
      bad5_r <= bad4_r;
      m6_r   <= mod_fix(v5_r, q5_r, two_n);
      bad6_r <= bad5_r;
    end
  end

  // ---------------- stages 7-8: t = floor((m*2^P + N)/2N), phase ----------------
  logic [QW:0]           num6;
  logic [QW:0]           num7_r, q7_r;
  logic                  bad7_r;
  logic [QW+1:0]         r7;
  logic [QW:0]           t7;
  logic [PHASE_BITS-1:0] ph8_r;
  logic                  bad8_r;
  assign num6 = (QW+1)'({m6_r, {PHASE_BITS{1'b0}}}) + (QW+1)'(len_r);
  always_comb begin
    r7 = (QW+2)'({1'b0, num7_r} - (QW+2)'(q7_r * (QW+1)'(two_n)));
    t7 = (r7 >= (QW+2)'(two_n)) ? q7_r + 1'b1 : q7_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      num7_r <= num6;
      q7_r   <= (QW+1)'(({{(RQ+1){1'b0}}, num6} * {{(QW+1){1'b0}}, qrec_r}) >> RQ);
      bad7_r <= bad6_r;
      ph8_r  <= PHASE_BITS'(0) - t7[PHASE_BITS-1:0];
      bad8_r <= bad7_r;
    end
  end

  // ---------------- CORDIC, one step per stage ----------------
  logic signed [ACC_W-1:0] cx_r [ST+1];
  logic signed [ACC_W-1:0] cy_r [ST+1];
  logic signed [ACC_W-1:0] cz_r [ST+1];
  logic                    fl_r [ST+1];
  logic                    bd_r [ST+1];
  logic [31:0]             ang;
  logic [31:0]             ang_f;
  logic                    flip0;

  always_comb begin
    ang   = 32'({ph8_r, {(32-PHASE_BITS){1'b0}}});
    flip0 = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
    ang_f = flip0 ? ang - 32'h8000_0000 : ang;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx_r[0] <= CORDIC_X0;
      cy_r[0] <= '0;
      cz_r[0] <= ACC_W'($signed(ang_f));
      fl_r[0] <= flip0;
      bd_r[0] <= bad8_r;
    end
  end

  for (genvar k = 0; k < ST; k++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (adv) begin
        fl_r[k+1] <= fl_r[k];
        bd_r[k+1] <= bd_r[k];
        if (!cz_r[k][ACC_W-1]) begin
          cx_r[k+1] <= cx_r[k] - (cy_r[k] >>> k);
          cy_r[k+1] <= cy_r[k] + (cx_r[k] >>> k);
          cz_r[k+1] <= cz_r[k] - turn_atan(k);
        end else begin
          cx_r[k+1] <= cx_r[k] + (cy_r[k] >>> k);
          cy_r[k+1] <= cy_r[k] - (cx_r[k] >>> k);
          cz_r[k+1] <= cz_r[k] + turn_atan(k);
        end
      end
    end
  end

  // ---------------- output: flip, round, saturate ----------------
  function automatic logic signed [OUT_BITS-1:0] rsat(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0]        mag;
    logic [ACC_W-1:0]        r;
    logic signed [ACC_W-1:0] lim;
    lim = ACC_W'((64'sd1 <<< (OUT_BITS - 1)) - 1);
    mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    r   = (mag + (ACC_W'(1) << (SH - 1))) >> SH;
    if ($signed(r) > lim) r = lim;
    return v[ACC_W-1] ? OUT_BITS'(-$signed(r)) : OUT_BITS'(r);
  endfunction

  logic signed [ACC_W-1:0] fx, fy;
  assign fx = fl_r[ST] ? -cx_r[ST] : cx_r[ST];
  assign fy = fl_r[ST] ? -cy_r[ST] : cy_r[ST];

  always_ff @(posedge clk) begin
    if (adv) begin
      out_bad_request <= bd_r[ST];
      out_sample_re   <= bd_r[ST] ? '0 : rsat(fx);
      out_sample_im   <= bd_r[ST] ? '0 : rsat(fy);
    end
  end

endmodule
